// File: src/rts_pkg.sv
package rts_pkg;

	localparam int MaxWidthDef    = 640;
	localparam int MaxHeightDef   = 480;
	localparam int TileDim        = 4;
	localparam int CfgWidthReset  = 160;
	localparam int CfgHeightReset = 120;
	localparam int QueueDepth     = 2;
	localparam int CfgIdxW        = 1;
	localparam int CfgDataW       = 8;
	localparam int PixelW         = 32;
	localparam int WordW          = 64;

	localparam logic [CfgIdxW-1:0] RegWidthTiles  = 1'b0;
	localparam logic [CfgIdxW-1:0] RegHeightTiles = 1'b1;

	// One pixel: red in bits 7:0, then green, blue, alpha.
	typedef logic [PixelW-1:0] pixel_t;

	// A complete 4x4 tile, indexed px[row][column].
	typedef struct packed {
		pixel_t [TileDim-1:0][TileDim-1:0] px;
		logic                              frame_end;
	} tile_t;

endpackage

// File: src/rts_front.sv
module rts_front #(
	parameter int MAX_WIDTH  = rts_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = rts_pkg::MaxHeightDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rts_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [rts_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         pix_valid,
	output logic                         pix_ready,
	input  rts_pkg::pixel_t              pix_data,
	output logic                         push,
	output rts_pkg::tile_t               push_tile,
	input  logic                         q_full
);
	import rts_pkg::*;

	localparam int TilesPerLine = MAX_WIDTH / TileDim;
	localparam int TilesPerCol  = MAX_HEIGHT / TileDim;
	localparam int ColW         = $clog2(MAX_WIDTH);
	localparam int LineW        = $clog2(MAX_HEIGHT);
	// Tile rows 0 to 2 live in the store; row 3 is captured in registers.
	localparam int BankDepth    = (TileDim - 1) * TilesPerLine;
	localparam int AddrW        = $clog2(BankDepth);

	function automatic logic [10:0] last_index(logic [8:0] raw, logic [8:0] max_tiles);
		logic [8:0] t;
		t = (raw == 9'd0) ? 9'd1 : raw;
		if (t > max_tiles) begin
			t = max_tiles;
		end
		return {t - 9'd1, 2'b11};
	endfunction

	logic [ColW-1:0]  wlast_q;
	logic [LineW-1:0] hlast_q;
	logic [ColW-1:0]  col_q;
	logic [LineW-1:0] line_q;

	logic [1:0]       row;
	logic [1:0]       lane;
	logic [1:0]       sel_row;
	logic             eol;
	logic             eoi;
	logic             tile_end;
	logic             acc;
	logic             wr_en;
	logic             rd_en;
	logic [AddrW-1:0] addr;

	pixel_t                 line_store [TileDim][BankDepth];
	pixel_t [TileDim-1:0]   rdata_q;
	pixel_t [TileDim-1:0]   row0_q;
	pixel_t [TileDim-1:0]   row1_q;
	pixel_t [TileDim-2:0]   r3_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= ColW'(last_index(9'(CfgWidthReset), 9'(TilesPerLine)));
			hlast_q <= LineW'(last_index(9'(CfgHeightReset), 9'(TilesPerCol)));
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegWidthTiles: begin
					wlast_q <= ColW'(last_index({1'b0, cfg_data}, 9'(TilesPerLine)));
				end
				RegHeightTiles: begin
					hlast_q <= LineW'(last_index({2'b00, cfg_data[6:0]}, 9'(TilesPerCol)));
				end
				default: begin
				end
			endcase
		end
	end

	assign row      = line_q[1:0];
	assign lane     = col_q[1:0];
	assign eol      = col_q >= wlast_q;
	assign eoi      = eol && (line_q >= hlast_q);
	assign tile_end = (row == 2'd3) && (lane == 2'd3);
	assign pix_ready = !(tile_end && q_full);
	assign acc      = pix_valid && pix_ready;

	// During the last line of a block, pixel in column k (0 to 2) of a tile fetches tile row k.
	assign sel_row = (row == 2'd3) ? lane : row;
	assign addr    = AddrW'(sel_row) * AddrW'(TilesPerLine) + AddrW'(col_q >> 2);
	assign wr_en   = acc && (row != 2'd3);
	assign rd_en   = acc && (row == 2'd3) && (lane != 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else if (acc) begin
			if (eol) begin
				col_q  <= '0;
				line_q <= (line_q >= hlast_q) ? '0 : line_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_store[lane][addr] <= pix_data;
		end
		if (rd_en) begin
			for (int b = 0; b < TileDim; b++) begin
				rdata_q[b] <= line_store[b][addr];
			end
		end
	end

	// The read issued at one pixel is consumed at the next pixel of the same tile.
	always_ff @(posedge clk) begin
		if (acc && (row == 2'd3)) begin
			unique case (lane)
				2'd0: begin
					r3_q[0] <= pix_data;
				end
				2'd1: begin
					row0_q  <= rdata_q;
					r3_q[1] <= pix_data;
				end
				2'd2: begin
					row1_q  <= rdata_q;
					r3_q[2] <= pix_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign push               = acc && tile_end;
	assign push_tile.px[0]    = row0_q;
	assign push_tile.px[1]    = row1_q;
	assign push_tile.px[2]    = rdata_q;
	assign push_tile.px[3]    = {pix_data, r3_q[2], r3_q[1], r3_q[0]};
	assign push_tile.frame_end = eoi;

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> q_full)
		else $error("pixel input stalled while the tile queue had room");
`endif

endmodule

// File: src/rts_queue.sv
module rts_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rts_pkg::tile_t push_tile,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output rts_pkg::tile_t head
);
	import rts_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	tile_t            ent_q [QueueDepth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;

	assign full  = cnt_q == CntW'(QueueDepth);
	assign valid = cnt_q != '0;
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_tile;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("tile pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("tile popped from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(QueueDepth))
		else $error("queue fill count out of range");
`endif

endmodule

// File: src/rts_back.sv
module rts_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  rts_pkg::tile_t             head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rts_pkg::WordW-1:0]  out_word,
	output logic                       out_last,
	output logic                       out_frame
);
	import rts_pkg::*;

	logic [2:0]             cnt_q;
	logic                   out_valid_q;
	logic [WordW-1:0]       out_word_q;
	logic                   out_last_q;
	logic                   out_frame_q;
	logic                   load;
	pixel_t [TileDim-1:0]   sel_px;
	logic [WordW-1:0]       word;

	assign load = q_valid && (!out_valid_q || out_ready);
	assign pop  = load && (cnt_q == 3'd7);

	// Words 0-3 carry alpha,red pairs of tile rows 0-3; words 4-7 green,blue pairs.
	always_comb begin
		sel_px = head.px[cnt_q[1:0]];
		word   = '0;
		for (int i = 0; i < TileDim; i++) begin
			if (cnt_q[2]) begin
				word[WordW-1-16*i -: 16] = {sel_px[i][15:8], sel_px[i][23:16]};
			end else begin
				word[WordW-1-16*i -: 16] = {sel_px[i][31:24], sel_px[i][7:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			cnt_q       <= cnt_q + 1'b1;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q  <= word;
			out_last_q  <= cnt_q == 3'd7;
			out_frame_q <= (cnt_q == 3'd7) && head.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_last  = out_last_q;
	assign out_frame = out_frame_q;

`ifndef ASSERT_OFF
	a_frame_on_tile_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_frame_q |-> out_last_q)
		else $error("frame end flagged on a word that does not close a tile");
	a_tile_held: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 3'd0 |-> q_valid)
		else $error("tile left the queue before all eight words were sent");
`endif

endmodule

// File: src/rgba8_tile_swizzler_top.sv
// A tile is queued when its closing pixel is accepted, then its first word registered;
// the eight words follow on consecutive cycles when the sink is ready.
// Throughput: one pixel per cycle in the first three lines of a block; in the fourth
// line closing pixels stall on a full queue, paced by the one-word-per-cycle output.
// Reset (arst_n, asynchronous, active low) clears counters, queue and output valid;
// the line store needs no clearing pass and is undefined until written.
module rgba8_tile_swizzler_top #(
	parameter int MAX_WIDTH  = rts_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = rts_pkg::MaxHeightDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [31:0]                  s_axis_tdata,  // red, green, blue, alpha
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [63:0]                  m_axis_tdata,  // tile_word
	output logic                         m_axis_tlast,  // last_in_tile
	output logic                         m_axis_tuser,  // last_in_frame
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rts_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [rts_pkg::CfgDataW-1:0] cfg_data
);
	import rts_pkg::*;

	logic  push;
	logic  q_full;
	logic  q_valid;
	logic  pop;
	tile_t push_tile;
	tile_t head;

	rts_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_valid(s_axis_tvalid),
		.pix_ready(s_axis_tready),
		.pix_data (s_axis_tdata),
		.push     (push),
		.push_tile(push_tile),
		.q_full   (q_full)
	);

	rts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tile(push_tile),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.head     (head)
	);

	rts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_word (m_axis_tdata),
		.out_last (m_axis_tlast),
		.out_frame(m_axis_tuser)
	);

endmodule
